>>> design/jsds_pkg.sv
// Shared types, marker constants and helpers for the JPEG frame dimension scanner.
`default_nettype none

package jsds_pkg;

    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_EOI    = 8'hD9;
    localparam logic [7:0] MARK_SOS    = 8'hDA;
    localparam logic [7:0] MARK_TEM    = 8'h01;
    localparam logic [7:0] MARK_RST0   = 8'hD0;
    localparam logic [7:0] MARK_RST7   = 8'hD7;
    localparam logic [7:0] MARK_SOF_LO = 8'hC0;
    localparam logic [7:0] MARK_SOF_HI = 8'hCF;

    localparam logic [15:0] LEN_MIN     = 16'd2;
    localparam logic [15:0] LEN_SOF_MIN = 16'd7;

    // Segment byte positions holding the frame dimensions
    localparam logic [15:0] IDX_HEIGHT_HI = 16'd3;
    localparam logic [15:0] IDX_HEIGHT_LO = 16'd4;
    localparam logic [15:0] IDX_WIDTH_HI  = 16'd5;
    localparam logic [15:0] IDX_WIDTH_LO  = 16'd6;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [3:0] {
        PH_SOI0,
        PH_SOI1,
        PH_SCAN,
        PH_FILL,
        PH_LENHI,
        PH_LENLO,
        PH_BODY,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic        status;
        logic [15:0] width;
        logic [15:0] height;
    } result_item_t;

    // Start-of-frame markers: C0-CF except DHT (C4), JPG (C8) and DAC (CC)
    function automatic logic is_sof(input logic [7:0] m);
        logic in_range;
        in_range = (m >= MARK_SOF_LO) && (m <= MARK_SOF_HI);
        return in_range && (m[1:0] != 2'b00 || m[3:2] == 2'b00);
    endfunction

endpackage

`default_nettype wire

>>> design/jsds_parser.sv
// Marker walker: per-byte state update and result decision for one JPEG file.
`default_nettype none

module jsds_parser
    import jsds_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire byte_item_t   item,
    output logic              emit,
    output result_item_t      res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] index_reg, index_next;
    logic        frame_reg, frame_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] width_reg, width_next;

    logic [7:0]  b;
    logic [15:0] seg_len;
    logic        len_bad;
    logic        seg_end;
    logic        dims_ok;
    logic        dec_ok;
    logic        dec_fail;

    assign b       = item.data_byte;
    assign seg_len = {remaining_reg[15:8], b};
    assign len_bad = (seg_len < LEN_MIN) || (frame_reg && (seg_len < LEN_SOF_MIN));
    assign seg_end = (remaining_reg == 16'd1);
    assign dims_ok = (height_next != '0) && (width_next != '0);

    // Next phase and decision
    always_comb
    begin
        phase_next = phase_reg;
        dec_ok     = 1'b0;
        dec_fail   = 1'b0;
        case (phase_reg)
            PH_SOI0:
            begin
                if (b == MARK_PREFIX) phase_next = PH_SOI1;
                else                  dec_fail   = 1'b1;
            end
            PH_SOI1:
            begin
                if (b == MARK_SOI) phase_next = PH_SCAN;
                else               dec_fail   = 1'b1;
            end
            PH_SCAN:
            begin
                if (b == MARK_PREFIX) phase_next = PH_FILL;
            end
            PH_FILL:
            begin
                if (b == MARK_PREFIX)
                begin
                    phase_next = PH_FILL;
                end
                else if (b inside {MARK_EOI, MARK_SOS})
                begin
                    dec_fail = 1'b1;
                end
                else if (b inside {MARK_TEM, [MARK_RST0:MARK_RST7]})
                begin
                    phase_next = PH_SCAN;
                end
                else
                begin
                    phase_next = PH_LENHI;
                end
            end
            PH_LENHI:
            begin
                phase_next = PH_LENLO;
            end
            PH_LENLO:
            begin
                if (len_bad)                 dec_fail   = 1'b1;
                else if (seg_len == LEN_MIN) phase_next = PH_SCAN;
                else                         phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                if (seg_end)
                begin
                    if (!frame_reg)   phase_next = PH_SCAN;
                    else if (dims_ok) dec_ok     = 1'b1;
                    else              dec_fail   = 1'b1;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
        if (dec_ok || dec_fail) phase_next = PH_DONE;
    end

    // Segment bookkeeping and dimension capture
    always_comb
    begin
        remaining_next = remaining_reg;
        index_next     = index_reg;
        frame_next     = frame_reg;
        height_next    = height_reg;
        width_next     = width_reg;
        case (phase_reg)
            PH_FILL:
            begin
                if (!(b inside {MARK_PREFIX, MARK_EOI, MARK_SOS, MARK_TEM,
                                [MARK_RST0:MARK_RST7]}))
                begin
                    frame_next = is_sof(b);
                end
            end
            PH_LENHI:
            begin
                remaining_next = {b, 8'h00};
            end
            PH_LENLO:
            begin
                if (!len_bad)
                begin
                    remaining_next = seg_len - LEN_MIN;
                    index_next     = LEN_MIN;
                    height_next    = '0;
                    width_next     = '0;
                end
            end
            PH_BODY:
            begin
                if (frame_reg)
                begin
                    if (index_reg == IDX_HEIGHT_HI)     height_next[15:8] = b;
                    else if (index_reg == IDX_HEIGHT_LO) height_next[7:0] = b;
                    else if (index_reg == IDX_WIDTH_HI)  width_next[15:8] = b;
                    else if (index_reg == IDX_WIDTH_LO)  width_next[7:0]  = b;
                end
                index_next     = index_reg + 16'd1;
                remaining_next = remaining_reg - 16'd1;
            end
            default:
            begin
                remaining_next = remaining_reg;
            end
        endcase
    end

    // One result per file: on the deciding byte, or a failure on the flagged byte
    always_comb
    begin
        emit = step && (phase_reg != PH_DONE) && (dec_ok || dec_fail || item.last_byte);
        if (dec_ok)
        begin
            res.status = STATUS_OK;
            res.width  = width_next;
            res.height = height_next;
        end
        else
        begin
            res.status = STATUS_FAIL;
            res.width  = '0;
            res.height = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SOI0;
            remaining_reg <= '0;
            index_reg     <= '0;
            frame_reg     <= 1'b0;
            height_reg    <= '0;
            width_reg     <= '0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                // start the next file from scratch
                phase_reg     <= PH_SOI0;
                remaining_reg <= '0;
                index_reg     <= '0;
                frame_reg     <= 1'b0;
                height_reg    <= '0;
                width_reg     <= '0;
            end
            else
            begin
                phase_reg     <= phase_next;
                remaining_reg <= remaining_next;
                index_reg     <= index_next;
                frame_reg     <= frame_next;
                height_reg    <= height_next;
                width_reg     <= width_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/jpeg_sof_dimension_scanner.sv
// Top level: input register, marker walker and result register.
// Result path: a byte's transfer loads the input register; its result loads the result register when the byte advances.
// Throughput: one byte per cycle; result stalls backpressure.
// A byte is taken while a finished result waits only if the input register is empty.
// Reset: rst_n clears the parser to expect a new file and empties both registers.
`default_nettype none

module jpeg_sof_dimension_scanner
    import jsds_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         data_valid,
    output logic              data_ready,
    input  wire byte_item_t   data,
    output logic              result_valid,
    input  wire logic         result_ready,
    output result_item_t      result
);

    logic         hold_valid_reg, hold_valid_next;
    byte_item_t   hold_reg;
    logic         res_valid_reg, res_valid_next;
    result_item_t res_reg;

    logic         advance;
    logic         emit;
    result_item_t res;

    // Advance the held byte when the result slot is free or draining this cycle
    assign advance    = hold_valid_reg && (!res_valid_reg || result_ready);
    assign data_ready = !hold_valid_reg || advance;

    jsds_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (hold_reg),
        .emit  (emit),
        .res   (res)
    );

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (data_valid && data_ready) hold_valid_next = 1'b1;
        else if (advance)             hold_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance && emit)              res_valid_next = 1'b1;
        else if (res_valid_reg && result_ready) res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && data_ready) hold_reg <= data;
        if (advance && emit)          res_reg  <= res;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire
